// ----- rtl/core/nlp_pkg.sv -----
// ----------------------------------------------------------------------------
// nlp_pkg
// Shared widths, defaults and result status codes for the next-permutation
// unit.
// ----------------------------------------------------------------------------
package nlp_pkg;

  localparam int BYTE_W      = 8;
  localparam int STATUS_W    = 2;
  localparam int MAX_LEN_DEF = 64;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_ANSWER = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 2'd2;

endpackage

// ----- rtl/core/nlp_store.sv -----
// ----------------------------------------------------------------------------
// nlp_store
// Word store: one write port, one read port with registered read data
// that holds while the read enable is low.
// ----------------------------------------------------------------------------
module nlp_store #(
  parameter int DEPTH = nlp_pkg::MAX_LEN_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [nlp_pkg::BYTE_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [nlp_pkg::BYTE_W-1:0] rdata
);
  import nlp_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/next_lexicographic_permutation_unit.sv -----
// ----------------------------------------------------------------------------
// next_lexicographic_permutation_unit
// Collects a word byte by byte and returns its next larger permutation.
// ----------------------------------------------------------------------------
// Send a word one byte per transfer on the input stream, tlast on its
// final byte. Bytes are accepted while the unit is loading. After the
// final byte the unit stops accepting and works on the stored word
// through a single read port and a single compare unit: the pivot scan,
// the successor scan, the swap, the suffix reversal pair by pair and
// the readout byte by byte (which waits while the output stalls), all
// paced by the one read port of the word store. For a word of n bytes
// the answer is the n bytes of the next permutation with status ok and
// tlast on the final one; a word with no larger permutation (one byte,
// or non-increasing) yields a single word with status no_answer, and a
// word longer than MAX_LEN a single word with status too_long, both with
// code 0 and tlast set. The output register lets the next word start
// loading while the final result still waits.
// ----------------------------------------------------------------------------
module next_lexicographic_permutation_unit #(
  parameter int MAX_LEN = nlp_pkg::MAX_LEN_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // input stream
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [nlp_pkg::BYTE_W-1:0]   s_tdata,  // [7:0] char_code
  input  logic                         s_tlast,  // last_char
  // output stream
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [nlp_pkg::BYTE_W-1:0]   m_tdata,  // [7:0] out_code
  output logic                         m_tlast,  // out_last
  output logic [nlp_pkg::STATUS_W-1:0] m_tuser   // [1:0] status
);
  import nlp_pkg::*;

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LW = $clog2(MAX_LEN + 1);

  // sequencer states
  localparam logic [3:0] S_LOAD   = 4'd0;
  localparam logic [3:0] S_PINIT  = 4'd1;   // read rightmost byte
  localparam logic [3:0] S_PINIT2 = 4'd2;   // latch it
  localparam logic [3:0] S_PRD    = 4'd3;   // pivot scan read
  localparam logic [3:0] S_PCMP   = 4'd4;   // pivot scan compare
  localparam logic [3:0] S_SRD    = 4'd5;   // successor scan read
  localparam logic [3:0] S_SCMP   = 4'd6;   // successor scan compare
  localparam logic [3:0] S_SW1    = 4'd7;   // pivot <= successor byte
  localparam logic [3:0] S_SW2    = 4'd8;   // successor <= pivot byte
  localparam logic [3:0] S_RRDLO  = 4'd9;
  localparam logic [3:0] S_RRDHI  = 4'd10;
  localparam logic [3:0] S_RWR1   = 4'd11;
  localparam logic [3:0] S_RWR2   = 4'd12;
  localparam logic [3:0] S_ERD    = 4'd13;  // readout read
  localparam logic [3:0] S_EOUT   = 4'd14;  // readout to output reg
  localparam logic [3:0] S_EST    = 4'd15;  // single status word

  logic [3:0]          state, state_next;
  logic [LW-1:0]       len, len_next;
  logic                ovf, ovf_next;
  logic [AW-1:0]       idx, idx_next;     // scan index, later hi / successor
  logic [AW-1:0]       lo, lo_next;       // reversal low end, readout index
  logic [AW-1:0]       piv, piv_next;
  logic [BYTE_W-1:0]   piv_val, piv_val_next;
  logic [BYTE_W-1:0]   hold, hold_next;   // right neighbor / successor / temp
  logic [STATUS_W-1:0] st, st_next;

  // output register
  logic                out_valid_next;
  logic [BYTE_W-1:0]   out_code, out_code_next;
  logic                out_last, out_last_next;
  logic [STATUS_W-1:0] out_st, out_st_next;

  // store ports
  logic                we, re;
  logic [AW-1:0]       waddr, raddr;
  logic [BYTE_W-1:0]   wdata, rdata;

  // shared compare unit: read byte against the pivot scan's right neighbor
  // or against the pivot byte
  logic [BYTE_W-1:0]   cmp_b;
  logic                cmp_lt, cmp_gt;

  logic                in_acc, out_free;
  logic                fits;

  nlp_store #(
    .DEPTH (MAX_LEN),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign cmp_b  = (state == S_PCMP) ? hold : piv_val;
  assign cmp_lt = rdata < cmp_b;
  assign cmp_gt = rdata > cmp_b;

  assign s_tready = (state == S_LOAD);
  assign in_acc   = s_tvalid & s_tready;
  assign out_free = ~m_tvalid | m_tready;
  assign fits     = (len < LW'(MAX_LEN));

  always_comb begin
    state_next     = state;
    len_next       = len;
    ovf_next       = ovf;
    idx_next       = idx;
    lo_next        = lo;
    piv_next       = piv;
    piv_val_next   = piv_val;
    hold_next      = hold;
    st_next        = st;
    out_valid_next = m_tvalid & ~m_tready;
    out_code_next  = out_code;
    out_last_next  = out_last;
    out_st_next    = out_st;
    we             = 1'b0;
    waddr          = len[AW-1:0];
    wdata          = s_tdata;
    re             = 1'b0;
    raddr          = idx;

    case (state)
      S_LOAD: begin
        if (in_acc) begin
          if (fits) begin
            we       = 1'b1;
            len_next = len + LW'(1);
          end else begin
            ovf_next = 1'b1;
          end
          if (s_tlast) begin
            if (!fits || ovf) begin
              st_next    = ST_TOO_LONG;
              state_next = S_EST;
            end else if (len_next < LW'(2)) begin
              st_next    = ST_NO_ANSWER;
              state_next = S_EST;
            end else begin
              state_next = S_PINIT;
            end
          end
        end
      end
      S_PINIT: begin
        re         = 1'b1;
        raddr      = AW'(len - LW'(1));
        state_next = S_PINIT2;
      end
      S_PINIT2: begin
        hold_next  = rdata;
        idx_next   = AW'(len - LW'(2));
        state_next = S_PRD;
      end
      S_PRD: begin
        re         = 1'b1;
        state_next = S_PCMP;
      end
      S_PCMP: begin
        if (cmp_lt) begin
          piv_next     = idx;
          piv_val_next = rdata;
          idx_next     = AW'(len - LW'(1));
          state_next   = S_SRD;
        end else if (idx == '0) begin
          st_next    = ST_NO_ANSWER;
          state_next = S_EST;
        end else begin
          hold_next  = rdata;
          idx_next   = idx - AW'(1);
          state_next = S_PRD;
        end
      end
      S_SRD: begin
        re         = 1'b1;
        state_next = S_SCMP;
      end
      S_SCMP: begin
        // always hits by the byte right of the pivot
        if (cmp_gt) begin
          hold_next  = rdata;
          state_next = S_SW1;
        end else begin
          idx_next   = idx - AW'(1);
          state_next = S_SRD;
        end
      end
      S_SW1: begin
        we         = 1'b1;
        waddr      = piv;
        wdata      = hold;
        state_next = S_SW2;
      end
      S_SW2: begin
        we       = 1'b1;
        waddr    = idx;
        wdata    = piv_val;
        lo_next  = piv + AW'(1);
        idx_next = AW'(len - LW'(1));
        if (LW'(piv) + LW'(2) < len) begin
          state_next = S_RRDLO;
        end else begin
          lo_next    = '0;
          state_next = S_ERD;
        end
      end
      S_RRDLO: begin
        re         = 1'b1;
        raddr      = lo;
        state_next = S_RRDHI;
      end
      S_RRDHI: begin
        re         = 1'b1;
        raddr      = idx;
        hold_next  = rdata;
        state_next = S_RWR1;
      end
      S_RWR1: begin
        we         = 1'b1;
        waddr      = lo;
        wdata      = rdata;
        state_next = S_RWR2;
      end
      S_RWR2: begin
        we    = 1'b1;
        waddr = idx;
        wdata = hold;
        if (LW'(lo) + LW'(2) < LW'(idx)) begin
          lo_next    = lo + AW'(1);
          idx_next   = idx - AW'(1);
          state_next = S_RRDLO;
        end else begin
          lo_next    = '0;
          state_next = S_ERD;
        end
      end
      S_ERD: begin
        re         = 1'b1;
        raddr      = lo;
        state_next = S_EOUT;
      end
      S_EOUT: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_code_next  = rdata;
          out_st_next    = ST_OK;
          out_last_next  = (LW'(lo) + LW'(1) == len);
          if (LW'(lo) + LW'(1) == len) begin
            len_next   = '0;
            ovf_next   = 1'b0;
            state_next = S_LOAD;
          end else begin
            lo_next    = lo + AW'(1);
            state_next = S_ERD;
          end
        end
      end
      S_EST: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_code_next  = '0;
          out_last_next  = 1'b1;
          out_st_next    = st;
          len_next       = '0;
          ovf_next       = 1'b0;
          state_next     = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      len      <= '0;
      ovf      <= 1'b0;
      idx      <= '0;
      lo       <= '0;
      piv      <= '0;
      st       <= ST_OK;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      len      <= len_next;
      ovf      <= ovf_next;
      idx      <= idx_next;
      lo       <= lo_next;
      piv      <= piv_next;
      st       <= st_next;
      m_tvalid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    piv_val  <= piv_val_next;
    hold     <= hold_next;
    out_code <= out_code_next;
    out_last <= out_last_next;
    out_st   <= out_st_next;
  end

  assign m_tdata = out_code;
  assign m_tlast = out_last;
  assign m_tuser = out_st;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the next-permutation unit: words are streamed in
// byte by byte, a local predictor works out the next larger permutation (or
// the no_answer / too_long status) and every output word is checked in order.
// ----------------------------------------------------------------------------
module tb_top;
  import nlp_pkg::*;

  localparam int WORD_CAP    = MAX_LEN_DEF;
  localparam int RAND_BYTES  = 380;
  localparam int DRAIN_CYC   = 8 * WORD_CAP + 50;  // drain wait after the queues empty
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [BYTE_W-1:0] code;
    logic              last;
  } in_byte_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   code;
    logic                last;
    logic [STATUS_W-1:0] status;
  } perm_out_t;

  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SLOW, RX_CHOKE} rx_mode_e;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [BYTE_W-1:0]   s_tdata;
  logic                s_tlast;
  logic                m_tvalid;
  logic                m_tready;
  logic [BYTE_W-1:0]   m_tdata;
  logic                m_tlast;
  logic [STATUS_W-1:0] m_tuser;

  // stimulus and expectations
  in_byte_t    byte_q[$];
  perm_out_t   perm_out_q[$];
  logic [7:0]  word_buf[$];

  // predictor state
  logic [7:0]  perm_store[WORD_CAP];
  int          perm_len;
  bit          perm_ovf;

  int          err_count;
  int          cycle_count;
  int          bytes_sent;
  int          words_sent;
  int          n_ok, n_none, n_long;
  int          results_seen;
  bit          in_taken;
  int          burst_left, gap_left;
  rx_mode_e    rx_mode;
  int          rx_left;

  next_lexicographic_permutation_unit #(.MAX_LEN(WORD_CAP)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Next-permutation predictor: called for every accepted input byte.
  function automatic void next_perm_predict(input logic [7:0] code, input logic last);
    int         piv;
    int         succ;
    int         i;
    int         lo, hi;
    logic [7:0] t;
    piv  = -1;
    succ = -1;
    if (perm_len < WORD_CAP) begin
      perm_store[perm_len] = code;
      perm_len++;
    end else begin
      perm_ovf = 1'b1;
    end
    if (!last) return;
    if (perm_ovf) begin
      perm_out_q.push_back('{code: 8'h00, last: 1'b1, status: ST_TOO_LONG});
      n_long++;
    end else begin
      // rightmost ascent
      i = perm_len - 2;
      while (i >= 0 && piv < 0) begin
        if (perm_store[i] < perm_store[i+1]) piv = i;
        i--;
      end
      if (piv < 0) begin
        perm_out_q.push_back('{code: 8'h00, last: 1'b1, status: ST_NO_ANSWER});
        n_none++;
      end else begin
        // rightmost byte above the pivot is the smallest larger one
        i = perm_len - 1;
        while (i > piv && succ < 0) begin
          if (perm_store[i] > perm_store[piv]) succ = i;
          i--;
        end
        t = perm_store[piv];
        perm_store[piv] = perm_store[succ];
        perm_store[succ] = t;
        lo = piv + 1;
        hi = perm_len - 1;
        while (lo < hi) begin
          t = perm_store[lo];
          perm_store[lo] = perm_store[hi];
          perm_store[hi] = t;
          lo++;
          hi--;
        end
        for (i = 0; i < perm_len; i++)
          perm_out_q.push_back('{code: perm_store[i], last: (i == perm_len - 1),
                                 status: ST_OK});
        n_ok++;
      end
    end
    perm_len = 0;
    perm_ovf = 1'b0;
  endfunction

  task automatic push_word();
    int i;
    for (i = 0; i < word_buf.size(); i++)
      byte_q.push_back('{code: word_buf[i], last: (i == word_buf.size() - 1)});
    word_buf.delete();
  endtask

  // Sender: bursts of random length, random gaps; valid held until taken.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'h00;
      s_tlast  <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      in_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'($urandom);
        s_tlast  <= 1'($urandom_range(0, 1));
      end else if (byte_q.size() > 0) begin
        s_tvalid <= 1'b1;
        s_tdata  <= byte_q[0].code;
        s_tlast  <= byte_q[0].last;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
                                                 : $urandom_range(0, 8);
          gap_left   = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 5);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Input monitor: feed accepted bytes to the predictor.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      in_taken = 1'b1;
      next_perm_predict(s_tdata, s_tlast);
      byte_q.pop_front();
      bytes_sent++;
      if (s_tlast) words_sent++;
    end
  end

  // Receiver: stall pattern switches between free-running, coin-flip,
  // one-in-four and mostly-stalled stretches.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 120);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_FREE:  m_tready <= 1'b1;
      RX_COIN:  m_tready <= 1'($urandom_range(0, 1));
      RX_SLOW:  m_tready <= (rx_left % 4 == 0);
      default:  m_tready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  // Output monitor: compare each accepted word against the oldest expectation.
  always @(posedge clk) begin
    perm_out_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (perm_out_q.size() == 0) begin
        $error("unexpected output word: code %0h last %0b status %0d",
               m_tdata, m_tlast, m_tuser);
        err_count++;
      end else begin
        want = perm_out_q.pop_front();
        if (m_tdata !== want.code) begin
          $error("out_code mismatch: expected %0h, got %0h", want.code, m_tdata);
          err_count++;
        end
        if (m_tlast !== want.last) begin
          $error("out_last mismatch: expected %0b, got %0b", want.last, m_tlast);
          err_count++;
        end
        if (m_tuser !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, m_tuser);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still queued, %0d words expected",
               cycle_count, byte_q.size(), perm_out_q.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int         nw;
    int         kind;
    int         len;
    int         v;
    int         base;
    int         i;
    int         rand_bytes;
    bit         narrow;

    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = 8'h00;
    s_tlast      = 1'b0;
    m_tready     = 1'b0;
    in_taken     = 1'b0;
    burst_left   = 0;
    gap_left     = 0;
    rx_mode      = RX_FREE;
    rx_left      = 0;
    err_count    = 0;
    cycle_count  = 0;
    bytes_sent   = 0;
    words_sent   = 0;
    results_seen = 0;
    n_ok         = 0;
    n_none       = 0;
    n_long       = 0;
    perm_len     = 0;
    perm_ovf     = 1'b0;
    rand_bytes   = 0;

    // directed words
    word_buf = '{8'h41};                               push_word(); // single byte
    word_buf = '{8'h00, 8'hFF};                        push_word(); // extremes, ascending
    word_buf = '{8'hFF, 8'h00};                        push_word(); // descending
    word_buf = '{8'h80, 8'h80};                        push_word(); // all equal
    word_buf = '{8'h01, 8'h02, 8'h03};                 push_word(); // ascent at the tail
    word_buf = '{8'h02, 8'h03, 8'h01};                 push_word(); // pivot at the head
    word_buf = '{8'h12, 8'h7F, 8'h55, 8'h55, 8'h30};   push_word(); // repeats in suffix
    word_buf = '{8'h01, 8'hFE, 8'h7F, 8'h80};          push_word();

    // random words: mostly short, some non-increasing, a few full or too long
    nw = 0;
    while (rand_bytes < RAND_BYTES) begin
      kind = $urandom_range(0, 99);
      if (nw == 2) kind = 0;
      if (nw == 5) kind = 5;
      narrow = $urandom_range(0, 1);
      base   = $urandom_range(0, 252);
      if (kind < 4) begin
        len = $urandom_range(WORD_CAP + 1, WORD_CAP + 8);
        for (i = 0; i < len; i++) word_buf.push_back(8'($urandom));
      end else if (kind < 7) begin
        len = WORD_CAP;
        for (i = 0; i < len; i++)
          word_buf.push_back(8'(narrow ? base + $urandom_range(0, 3) : $urandom));
      end else if (kind < 22) begin
        // non-increasing word, no larger permutation
        len = $urandom_range(1, 8);
        v = $urandom_range(0, 255);
        for (i = 0; i < len; i++) begin
          word_buf.push_back(8'(v));
          v = v - $urandom_range(0, v < 40 ? v : 40);
        end
      end else begin
        len = $urandom_range(0, 4) == 0 ? $urandom_range(9, 24) : $urandom_range(1, 8);
        for (i = 0; i < len; i++)
          word_buf.push_back(8'(narrow ? base + $urandom_range(0, 3) : $urandom));
      end
      rand_bytes += len;
      nw++;
      push_word();
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (byte_q.size() != 0 || perm_out_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("ran %0d words (%0d bytes): %0d permuted, %0d without successor, %0d oversize",
             words_sent, bytes_sent, n_ok, n_none, n_long);
    $display("%0d output words checked in %0d cycles, %0d errors",
             results_seen, cycle_count, err_count);
    if (err_count == 0 && perm_out_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
